[hw/rtl/scb_pkg.sv]
`default_nettype none

package scb_pkg;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned NUM_CHAINS = 3;

  // chain index inside the buffer and flag vectors
  localparam int unsigned CH_PLAYER1 = 0;
  localparam int unsigned CH_PLAYER2 = 1;
  localparam int unsigned CH_CABINET = 2;

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [NUM_CHAINS-1:0] flags_t;

  // one result word as it leaves the core
  typedef struct packed {
    logic   load_level;
    logic   clock_level;
    logic   frame_done;
    word_t  player1_word;
    word_t  player2_word;
    word_t  cabinet_word;
    flags_t changed_flags;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/scb_core.sv]
`default_nettype none

module scb_core #(
  parameter int unsigned BITS_PER_CHAIN = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic             pin_player1,
  input  wire logic             pin_player2,
  input  wire logic             pin_cabinet,
  input  wire scb_pkg::flags_t  clear_mask,
  output scb_pkg::result_t      result_nxt
);

  localparam int unsigned CNT_W = $clog2(BITS_PER_CHAIN + 1);

  typedef enum logic [1:0] {
    PH_SETUP = 2'd0,
    PH_LOAD  = 2'd1,
    PH_READ  = 2'd2,
    PH_SHIFT = 2'd3
  } phase_t;

  phase_t                                      phase_r, phase_nxt;
  logic [CNT_W-1:0]                            cnt_r, cnt_nxt;
  logic [scb_pkg::NUM_CHAINS-1:0][scb_pkg::WORD_W-1:0] buf_r, buf_nxt;
  logic [scb_pkg::NUM_CHAINS-1:0][scb_pkg::WORD_W-1:0] word_r, word_nxt;
  scb_pkg::flags_t                             chg_r, chg_nxt;
  logic                                        load_r, load_nxt;
  logic                                        clock_r, clock_nxt;
  logic                                        done;
  scb_pkg::flags_t                             pressed;

  // pins are active low
  assign pressed = ~{pin_cabinet, pin_player2, pin_player1};

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    buf_nxt   = buf_r;
    word_nxt  = word_r;
    chg_nxt   = chg_r & ~clear_mask;
    load_nxt  = load_r;
    clock_nxt = clock_r;
    done      = 1'b0;
    case (phase_r)
      PH_SETUP: begin
        load_nxt  = 1'b0;
        clock_nxt = 1'b0;
        chg_nxt   = '0;
        phase_nxt = PH_LOAD;
      end
      PH_LOAD: begin
        buf_nxt   = '0;
        load_nxt  = 1'b1;
        clock_nxt = 1'b0;
        cnt_nxt   = '0;
        phase_nxt = PH_READ;
      end
      PH_READ: begin
        load_nxt  = 1'b0;
        clock_nxt = 1'b0;
        cnt_nxt   = cnt_r + CNT_W'(1);
        for (int i = 0; i < scb_pkg::NUM_CHAINS; i++) begin
          buf_nxt[i] = buf_r[i] | scb_pkg::WORD_W'(pressed[i]);
        end
        if (cnt_nxt >= CNT_W'(BITS_PER_CHAIN)) begin
          for (int i = 0; i < scb_pkg::NUM_CHAINS; i++) begin
            if (buf_nxt[i] != word_r[i]) begin
              chg_nxt[i]  = 1'b1;
              word_nxt[i] = buf_nxt[i];
            end
          end
          done      = 1'b1;
          phase_nxt = PH_LOAD;
        end else begin
          phase_nxt = PH_SHIFT;
        end
      end
      PH_SHIFT: begin
        clock_nxt = 1'b1;
        for (int i = 0; i < scb_pkg::NUM_CHAINS; i++) begin
          buf_nxt[i] = {buf_r[i][scb_pkg::WORD_W-2:0], 1'b0};
        end
        phase_nxt = PH_READ;
      end
      default: begin
        phase_nxt = PH_SETUP;
      end
    endcase
  end

  always_comb begin
    result_nxt.load_level    = load_nxt;
    result_nxt.clock_level   = clock_nxt;
    result_nxt.frame_done    = done;
    result_nxt.player1_word  = word_nxt[scb_pkg::CH_PLAYER1];
    result_nxt.player2_word  = word_nxt[scb_pkg::CH_PLAYER2];
    result_nxt.cabinet_word  = word_nxt[scb_pkg::CH_CABINET];
    result_nxt.changed_flags = chg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SETUP;
      cnt_r   <= '0;
      buf_r   <= '0;
      word_r  <= '0;
      chg_r   <= '0;
      load_r  <= 1'b0;
      clock_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      buf_r   <= buf_nxt;
      word_r  <= word_nxt;
      chg_r   <= chg_nxt;
      load_r  <= load_nxt;
      clock_r <= clock_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/shift_chain_button_scanner.sv]
`default_nettype none

// Scanner for three daisy-chained parallel-in serial-out button registers
// (player 1, player 2, cabinet). Every accepted input word is one scan tick
// and yields exactly one output word: the load and shift clock levels to
// drive, a frame_done pulse, the three latched 16-bit button words (first
// shifted bit in bit BITS_PER_CHAIN-1, upper bits zero on short chains) and
// three sticky changed flags. The scan walks setup, load, then alternating
// read and shift ticks; a frame takes 2*BITS_PER_CHAIN ticks from load to
// the read that latches the words. in_clear_mask drops changed flags before
// the tick is applied, so a flag raised by the same tick survives. Rate is
// one word per clock: the tick logic sits between the scan state registers
// and a two-entry output buffer (output register plus skid), and in_ready
// drops only while both entries hold results not yet taken. Each result is
// registered in the output register, or in the skid entry when that is held.
module shift_chain_button_scanner #(
  parameter int unsigned BITS_PER_CHAIN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_pin_player1,
  input  wire logic        in_pin_player2,
  input  wire logic        in_pin_cabinet,
  input  wire logic [2:0]  in_clear_mask,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_load_level,
  output logic             out_clock_level,
  output logic             out_frame_done,
  output logic [15:0]      out_player1_word,
  output logic [15:0]      out_player2_word,
  output logic [15:0]      out_cabinet_word,
  output logic [2:0]       out_changed_flags
);

  logic              in_take;
  logic              out_take;
  scb_pkg::result_t  res_nxt;

  // output register and skid entry
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  scb_pkg::result_t  out_r, out_nxt;
  scb_pkg::result_t  skid_r, skid_nxt;

  assign in_ready = ~skid_valid_r;
  assign in_take  = in_valid & in_ready;
  assign out_take = out_valid_r & out_ready;

  scb_core #(
    .BITS_PER_CHAIN (BITS_PER_CHAIN)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_take),
    .pin_player1 (in_pin_player1),
    .pin_player2 (in_pin_player2),
    .pin_cabinet (in_pin_cabinet),
    .clear_mask  (in_clear_mask),
    .result_nxt  (res_nxt)
  );

  // two-entry buffer: skid only fills when the output register is stuck
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_take;
        out_nxt       = res_nxt;
      end
    end else if (in_take) begin
      if (!out_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res_nxt;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_load_level    = out_r.load_level;
  assign out_clock_level   = out_r.clock_level;
  assign out_frame_done    = out_r.frame_done;
  assign out_player1_word  = out_r.player1_word;
  assign out_player2_word  = out_r.player2_word;
  assign out_cabinet_word  = out_r.cabinet_word;
  assign out_changed_flags = out_r.changed_flags;

endmodule

`default_nettype wire

[hw/rtl/scb_checker.sv]
`default_nettype none

module scb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_load_level,
  input wire logic        out_clock_level,
  input wire logic        out_frame_done,
  input wire logic [15:0] out_player1_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_player1_word))
    else $error("result word dropped or changed while stalled");

  // backpressure only when a result is waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // load and shift clock never driven high together
  a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_load_level && out_clock_level))
    else $error("load and clock high in one word");

  // the frame ends on a read tick, both lines low
  a_done_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_load_level && !out_clock_level)
    else $error("frame_done outside a read tick");

endmodule

bind shift_chain_button_scanner scb_checker u_scb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_load_level   (out_load_level),
  .out_clock_level  (out_clock_level),
  .out_frame_done   (out_frame_done),
  .out_player1_word (out_player1_word)
);

`default_nettype wire
